### rtl/core/wtsp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the world-to-screen projection pipeline.
// Depends on nothing; imported by world_to_screen_projection.
package wtsp_pkg;

    // Screen size and the integer halves used by the pixel mapping.
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;
    localparam int HALF_W        = SCREEN_WIDTH / 2;
    localparam int HALF_H        = SCREEN_HEIGHT / 2;

    // Field and datapath widths.
    localparam int PT_W   = 24;          // world coordinate, Q16.8
    localparam int MAT_W  = 32;          // matrix element, Q16.16
    localparam int PROD_W = PT_W + MAT_W; // one product, Q.24
    localparam int TR_W   = MAT_W + 8;   // translation scaled to Q.24
    localparam int CLIP_W = PROD_W + 2;  // sum of three products and translation
    localparam int HALF_BITS = 13;       // holds a half screen up to 4096
    localparam int NUM_W  = CLIP_W + HALF_BITS; // magnitude times half screen
    localparam int QBITS  = 17;          // quotient bits worked out before saturation
    localparam int CMP_W  = CLIP_W + QBITS;
    localparam int RES_W  = 20;          // pixel before saturation
    localparam int PIX_W  = 16;

    // Configuration registers.
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int REG_IDX_W = 4;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

    localparam logic [REG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

    // Minimum clip w of a visible point: 0.1 in Q.24, rounded up.
    localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(1677722);

    // One divider lane: partial remainder, quotient so far, saturation flag and sign.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QBITS-1:0] quo;
        logic             sat;
        logic             neg;
    } div_lane_t;

endpackage

### rtl/core/world_to_screen_projection.sv
`timescale 1ns / 1ps
// World-to-screen projection: matrix transform, perspective divide, pixel map.
// Depends on wtsp_pkg.
// Pipeline: an accepted input word passes the three front stages, the divider
// set-up stage, the 17-stage restoring divider and the output register before
// it leaves as its result word.
// Throughput: one word per cycle; the whole pipeline advances when the output
// register is empty or being taken.
// Reset: synchronous, active low; clears all valid bits and loads the identity
// matrix into the configuration registers.
module world_to_screen_projection (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wtsp_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [wtsp_pkg::REG_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [wtsp_pkg::PT_W-1:0] s_point_x,
    input  logic signed [wtsp_pkg::PT_W-1:0] s_point_y,
    input  logic signed [wtsp_pkg::PT_W-1:0] s_point_z,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_visible,
    output logic signed [wtsp_pkg::PIX_W-1:0] m_pixel_x,
    output logic signed [wtsp_pkg::PIX_W-1:0] m_pixel_y
);
    import wtsp_pkg::*;

    logic [REG_W-1:0] cfg_reg [NUM_REGS];
    logic             pipe_en;
    logic             out_vld_reg;

    // Whole pipeline moves when the output word is empty or being taken.
    assign pipe_en   = ~out_vld_reg | m_ready;
    assign s_ready   = pipe_en;
    assign cfg_ready = 1'b1;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_ROW0_COLS01[2:0]] <= ONE_LO;
            cfg_reg[REG_ROW0_COLS23[2:0]] <= '0;
            cfg_reg[REG_ROW1_COLS01[2:0]] <= ONE_HI;
            cfg_reg[REG_ROW1_COLS23[2:0]] <= '0;
            cfg_reg[REG_ROW2_COLS01[2:0]] <= '0;
            cfg_reg[REG_ROW2_COLS23[2:0]] <= ONE_LO;
            cfg_reg[REG_ROW3_COLS01[2:0]] <= '0;
            cfg_reg[REG_ROW3_COLS23[2:0]] <= ONE_HI;
        end else if (cfg_valid && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Stage 1: nine products and three translations (rows 0, 1 and 3).
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [TR_W-1:0]   tr_reg [3];
    logic                     vld1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (pipe_en) begin
            vld1_reg <= s_valid;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        localparam int ROW = (r == 2) ? 3 : r;
        logic signed [MAT_W-1:0] m0, m1, m2, m3;
        assign m0 = cfg_reg[2*ROW][MAT_W-1:0];
        assign m1 = cfg_reg[2*ROW][REG_W-1:MAT_W];
        assign m2 = cfg_reg[2*ROW+1][MAT_W-1:0];
        assign m3 = cfg_reg[2*ROW+1][REG_W-1:MAT_W];
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                prod_reg[r][0] <= PROD_W'(s_point_x) * PROD_W'(m0);
                prod_reg[r][1] <= PROD_W'(s_point_y) * PROD_W'(m1);
                prod_reg[r][2] <= PROD_W'(s_point_z) * PROD_W'(m2);
                tr_reg[r]      <= {m3, 8'd0};
            end
        end
    end

    // Stage 2: clip coordinates x, y and w.
    logic signed [CLIP_W-1:0] clip_reg [3];
    logic                     vld2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (pipe_en) begin
            vld2_reg <= vld1_reg;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_sum
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                clip_reg[r] <= CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                             + CLIP_W'(prod_reg[r][2]) + CLIP_W'(tr_reg[r]);
            end
        end
    end

    // Stage 3: visibility, signs and scaled magnitudes (x lane 0, y lane 1).
    logic [NUM_W-1:0]  num_reg [2];
    logic              neg3_reg [2];
    logic [CLIP_W-1:0] den_reg;
    logic              vis3_reg;
    logic              vld3_reg;
    logic signed [CLIP_W-1:0] cval [2];
    logic [CLIP_W-1:0]        cmag [2];

    assign cval[0] = clip_reg[0];
    assign cval[1] = -clip_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (pipe_en) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            den_reg  <= clip_reg[2];
            vis3_reg <= (clip_reg[2] >= W_MIN);
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_mag
        localparam int HALF = (l == 0) ? HALF_W : HALF_H;
        assign cmag[l] = cval[l][CLIP_W-1] ? CLIP_W'(-cval[l]) : CLIP_W'(cval[l]);
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                num_reg[l]  <= NUM_W'(cmag[l]) * NUM_W'(HALF);
                neg3_reg[l] <= cval[l][CLIP_W-1];
            end
        end
    end

    // Divider: stage 0 flags quotients that saturate, then one bit a stage.
    div_lane_t         lane_reg [QBITS+1][2];
    logic [CLIP_W-1:0] dden_reg [QBITS+1];
    logic              dvis_reg [QBITS+1];
    logic              dvld_reg [QBITS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg[0] <= 1'b0;
        end else if (pipe_en) begin
            dvld_reg[0] <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dden_reg[0] <= den_reg;
            dvis_reg[0] <= vis3_reg;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_div0
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                lane_reg[0][l].rem <= num_reg[l];
                lane_reg[0][l].quo <= '0;
                lane_reg[0][l].neg <= neg3_reg[l];
                lane_reg[0][l].sat <= (CMP_W'(num_reg[l]) >= {den_reg, {QBITS{1'b0}}});
            end
        end
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_div
        localparam int BIT = QBITS - 1 - k;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvld_reg[k+1] <= 1'b0;
            end else if (pipe_en) begin
                dvld_reg[k+1] <= dvld_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                dden_reg[k+1] <= dden_reg[k];
                dvis_reg[k+1] <= dvis_reg[k];
            end
        end
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [CMP_W-1:0] shd;
            logic [CMP_W-1:0] rext;
            logic             take;
            assign shd  = CMP_W'(dden_reg[k]) << BIT;
            assign rext = CMP_W'(lane_reg[k][l].rem);
            assign take = (rext >= shd);
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    lane_reg[k+1][l].rem <= take ? NUM_W'(rext - shd) : lane_reg[k][l].rem;
                    lane_reg[k+1][l].quo <= lane_reg[k][l].quo
                                          | (QBITS'(take) << BIT);
                    lane_reg[k+1][l].sat <= lane_reg[k][l].sat;
                    lane_reg[k+1][l].neg <= lane_reg[k][l].neg;
                end
            end
        end
    end

    // Output stage: offset by the half screen, round toward zero, saturate; zero when not visible.
    logic signed [PIX_W-1:0] pix_reg [2];
    logic                    vis_out_reg;
    logic signed [PIX_W-1:0] pix_next [2];

    for (genvar l = 0; l < 2; l++) begin : g_out
        localparam int HALF = (l == 0) ? HALF_W : HALF_H;
        logic [QBITS:0]          q;
        logic                    corr;
        logic signed [RES_W-1:0] res;
        always_comb begin
            q    = lane_reg[QBITS][l].sat ? {1'b1, {QBITS{1'b0}}}
                                          : {1'b0, lane_reg[QBITS][l].quo};
            corr = (q < (QBITS+1)'(HALF)) && (lane_reg[QBITS][l].rem != '0);
            if (lane_reg[QBITS][l].neg) begin
                res = RES_W'(HALF) - RES_W'(q) - RES_W'(corr);
            end else begin
                res = RES_W'(HALF) + RES_W'(q);
            end
            if (!dvis_reg[QBITS]) begin
                pix_next[l] = '0;
            end else if (res > RES_W'(32767)) begin
                pix_next[l] = 16'sh7FFF;
            end else if (res < -RES_W'(32768)) begin
                pix_next[l] = 16'sh8000;
            end else begin
                pix_next[l] = res[PIX_W-1:0];
            end
        end
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                pix_reg[l] <= pix_next[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            out_vld_reg <= dvld_reg[QBITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            vis_out_reg <= dvis_reg[QBITS];
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_visible = vis_out_reg;
    assign m_pixel_x = pix_reg[0];
    assign m_pixel_y = pix_reg[1];

endmodule
